>>> rtl/sets_pkg.sv
// ----------------------------------------------------------------------------
// sets_pkg: shared types and constants of the threshold error sweep
// Holds the request structs of both channels, the job passed from the edge
// sweep to the divider, register indexes and the divider state type.
// ----------------------------------------------------------------------------
package sets_pkg;

    // Longest run; the edge that reaches it closes the run.
    localparam int MAX_EDGES   = 256;
    localparam int CNT_W       = $clog2(MAX_EDGES + 1);

    // Field widths.
    localparam int W_W         = 32;
    localparam int PAIR_W      = 40;
    localparam int SUM_W       = 48;
    localparam int DIFF_W      = 49;
    localparam int NUM_W       = 49;
    localparam int DEN_W       = 50;
    localparam int ERR_W       = 32;

    // Depth of the queue between the sweep and the divider.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Quotient bits, one per divider step.
    localparam int DIV_STEPS   = ERR_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Q16.16 range ends.
    localparam logic signed [W_W-1:0] Q16_MIN = {1'b1, {(W_W-1){1'b0}}};
    localparam logic signed [W_W-1:0] Q16_MAX = {1'b0, {(W_W-1){1'b1}}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_POS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_NEG = 1'b1;

    // One input request: an edge of the sorted run.
    typedef struct packed {
        logic signed [W_W-1:0]    edge_weight;
        logic        [PAIR_W-1:0] positive_pairs;
        logic        [PAIR_W-1:0] negative_pairs;
        logic                     final_edge;
    } in_item_t;

    // One result request: the outcome of a run.
    typedef struct packed {
        logic signed [W_W-1:0]   best_threshold;
        logic        [ERR_W-1:0] best_error;
        logic                    zero_total;
    } out_item_t;

    // Finished run waiting for its division.
    typedef struct packed {
        logic signed [W_W-1:0]   threshold;
        logic        [NUM_W-1:0] numer;
        logic        [DEN_W-1:0] denom;
        logic                    zero;
    } job_t;

    // Divider sequencer states.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } div_state_t;

endpackage

>>> rtl/sets_fifo.sv
// ----------------------------------------------------------------------------
// sets_fifo: short job queue
// Decouples the edge sweep from the divider so that each side stalls alone.
// ----------------------------------------------------------------------------
module sets_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sets_pkg::job_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output sets_pkg::job_t rd_data,
    output logic           q_empty
);

    sets_pkg::job_t                    slot_reg [sets_pkg::QUEUE_DEPTH];
    logic [sets_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sets_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [sets_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sets_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [sets_pkg::QCNT_W-1:0]       count_reg;
    logic [sets_pkg::QCNT_W-1:0]       count_next;

    assign q_full  = (count_reg == sets_pkg::QCNT_W'(sets_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            if (wr_ptr_reg == sets_pkg::QPTR_W'(sets_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            if (rd_ptr_reg == sets_pkg::QPTR_W'(sets_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/sets_front.sv
// ----------------------------------------------------------------------------
// sets_front: edge sweep
// Takes one edge per cycle unless full, keeps the running and best
// differences and the sums, and on the run's last edge queues a division job.
// ----------------------------------------------------------------------------
module sets_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  sets_pkg::in_item_t            item,
    output logic                          full,
    input  logic [sets_pkg::SUM_W-1:0]    extra_pos,
    input  logic [sets_pkg::SUM_W-1:0]    extra_neg,
    input  logic                          q_full,
    output logic                          q_push,
    output sets_pkg::job_t                q_job
);

    // Run state.
    logic signed [sets_pkg::W_W-1:0]    prev_w_reg;
    logic signed [sets_pkg::W_W-1:0]    prev_w_next;
    logic                               have_prev_reg;
    logic                               have_prev_next;
    logic signed [sets_pkg::DIFF_W-1:0] run_diff_reg;
    logic signed [sets_pkg::DIFF_W-1:0] run_diff_next;
    logic signed [sets_pkg::DIFF_W-1:0] best_diff_reg;
    logic signed [sets_pkg::DIFF_W-1:0] best_diff_next;
    logic signed [sets_pkg::W_W-1:0]    best_thr_reg;
    logic signed [sets_pkg::W_W-1:0]    best_thr_next;
    logic [sets_pkg::SUM_W-1:0]         pos_sum_reg;
    logic [sets_pkg::SUM_W-1:0]         pos_sum_next;
    logic [sets_pkg::SUM_W-1:0]         neg_sum_reg;
    logic [sets_pkg::SUM_W-1:0]         neg_sum_next;
    logic [sets_pkg::CNT_W-1:0]         cnt_reg;
    logic [sets_pkg::CNT_W-1:0]         cnt_next;

    // Snapshot of a closed run, finished in the following cycle.
    logic                               fin_valid_reg;
    logic                               fin_valid_next;
    logic signed [sets_pkg::DIFF_W-1:0] fin_run_reg;
    logic signed [sets_pkg::DIFF_W-1:0] fin_best_reg;
    logic signed [sets_pkg::W_W-1:0]    fin_thr_reg;
    logic signed [sets_pkg::W_W-1:0]    fin_w_reg;
    logic [sets_pkg::SUM_W-1:0]         fin_pos_reg;
    logic [sets_pkg::SUM_W-1:0]         fin_neg_reg;

    // Per-edge terms.
    logic                               accept;
    logic                               last;
    logic signed [sets_pkg::W_W-1:0]    w;
    logic signed [sets_pkg::W_W-1:0]    thr_lo;
    logic signed [sets_pkg::W_W:0]      mid_sum;
    logic signed [sets_pkg::DIFF_W-1:0] best1;
    logic signed [sets_pkg::W_W-1:0]    thr1;
    logic signed [sets_pkg::DIFF_W+1:0] run_wide;
    logic signed [sets_pkg::DIFF_W-1:0] run_new;
    logic [sets_pkg::SUM_W:0]           pos_add;
    logic [sets_pkg::SUM_W:0]           neg_add;
    logic [sets_pkg::SUM_W-1:0]         pos_new;
    logic [sets_pkg::SUM_W-1:0]         neg_new;

    // Finish terms.
    logic signed [sets_pkg::DIFF_W-1:0] best2;
    logic signed [sets_pkg::W_W-1:0]    thr2;
    logic signed [sets_pkg::DIFF_W+1:0] num_a;
    logic signed [sets_pkg::DIFF_W+1:0] num_b;
    logic signed [sets_pkg::DIFF_W+1:0] num_c;
    logic signed [sets_pkg::DIFF_W+1:0] num_wide;

    // A new edge waits only while a closed run cannot leave for the queue.
    assign full   = fin_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = fin_valid_reg && !q_full;
    assign w      = item.edge_weight;
    assign last   = item.final_edge ||
                    (cnt_reg == sets_pkg::CNT_W'(sets_pkg::MAX_EDGES - 1));

    // Candidate before the edge: first weight minus one LSB, or the midpoint.
    always_comb
    begin
        thr_lo  = (w == sets_pkg::Q16_MIN) ? w : w - sets_pkg::W_W'(1);
        mid_sum = {prev_w_reg[sets_pkg::W_W-1], prev_w_reg} + {w[sets_pkg::W_W-1], w};
        best1   = best_diff_reg;
        thr1    = best_thr_reg;
        if (!have_prev_reg)
        begin
            best1 = '0;
            thr1  = thr_lo;
        end
        else if ((prev_w_reg != w) && (run_diff_reg < best_diff_reg))
        begin
            best1 = run_diff_reg;
            // Floor of the half sum is the arithmetic shift.
            thr1  = mid_sum[sets_pkg::W_W:1];
        end
    end

    // Running difference with saturation, and saturating pair sums.
    always_comb
    begin
        run_wide = {{2{run_diff_reg[sets_pkg::DIFF_W-1]}}, run_diff_reg}
                 + $signed({{(sets_pkg::DIFF_W + 2 - sets_pkg::PAIR_W){1'b0}},
                            item.negative_pairs})
                 - $signed({{(sets_pkg::DIFF_W + 2 - sets_pkg::PAIR_W){1'b0}},
                            item.positive_pairs});
        if (run_wide[sets_pkg::DIFF_W+1:sets_pkg::DIFF_W-1] == 3'b000 ||
            run_wide[sets_pkg::DIFF_W+1:sets_pkg::DIFF_W-1] == 3'b111)
            run_new = run_wide[sets_pkg::DIFF_W-1:0];
        else if (run_wide[sets_pkg::DIFF_W+1])
            run_new = {1'b1, {(sets_pkg::DIFF_W-1){1'b0}}};
        else
            run_new = {1'b0, {(sets_pkg::DIFF_W-1){1'b1}}};

        pos_add = {1'b0, pos_sum_reg}
                + {{(sets_pkg::SUM_W + 1 - sets_pkg::PAIR_W){1'b0}}, item.positive_pairs};
        neg_add = {1'b0, neg_sum_reg}
                + {{(sets_pkg::SUM_W + 1 - sets_pkg::PAIR_W){1'b0}}, item.negative_pairs};
        pos_new = pos_add[sets_pkg::SUM_W] ? '1 : pos_add[sets_pkg::SUM_W-1:0];
        neg_new = neg_add[sets_pkg::SUM_W] ? '1 : neg_add[sets_pkg::SUM_W-1:0];
    end

    // Next run state: update on an edge, clear when the run closes.
    always_comb
    begin
        prev_w_next    = prev_w_reg;
        have_prev_next = have_prev_reg;
        run_diff_next  = run_diff_reg;
        best_diff_next = best_diff_reg;
        best_thr_next  = best_thr_reg;
        pos_sum_next   = pos_sum_reg;
        neg_sum_next   = neg_sum_reg;
        cnt_next       = cnt_reg;
        fin_valid_next = fin_valid_reg;
        if (q_push)
            fin_valid_next = 1'b0;
        if (accept)
        begin
            if (last)
            begin
                prev_w_next    = '0;
                have_prev_next = 1'b0;
                run_diff_next  = '0;
                best_diff_next = '0;
                best_thr_next  = '0;
                pos_sum_next   = '0;
                neg_sum_next   = '0;
                cnt_next       = '0;
                fin_valid_next = 1'b1;
            end
            else
            begin
                prev_w_next    = w;
                have_prev_next = 1'b1;
                run_diff_next  = run_new;
                best_diff_next = best1;
                best_thr_next  = thr1;
                pos_sum_next   = pos_new;
                neg_sum_next   = neg_new;
                cnt_next       = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_w_reg    <= '0;
            have_prev_reg <= 1'b0;
            run_diff_reg  <= '0;
            best_diff_reg <= '0;
            best_thr_reg  <= '0;
            pos_sum_reg   <= '0;
            neg_sum_reg   <= '0;
            cnt_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            prev_w_reg    <= prev_w_next;
            have_prev_reg <= have_prev_next;
            run_diff_reg  <= run_diff_next;
            best_diff_reg <= best_diff_next;
            best_thr_reg  <= best_thr_next;
            pos_sum_reg   <= pos_sum_next;
            neg_sum_reg   <= neg_sum_next;
            cnt_reg       <= cnt_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    // Snapshot of the closed run.
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            fin_run_reg  <= run_new;
            fin_best_reg <= best1;
            fin_thr_reg  <= thr1;
            fin_w_reg    <= w;
            fin_pos_reg  <= pos_new;
            fin_neg_reg  <= neg_new;
        end
    end

    // Outer candidate after the last edge, then numerator and denominator.
    always_comb
    begin
        best2 = fin_best_reg;
        thr2  = fin_thr_reg;
        if (fin_run_reg < fin_best_reg)
        begin
            best2 = fin_run_reg;
            thr2  = (fin_w_reg == sets_pkg::Q16_MAX) ? fin_w_reg
                                                     : fin_w_reg + sets_pkg::W_W'(1);
        end
        num_a    = $signed({{(sets_pkg::DIFF_W + 2 - sets_pkg::SUM_W){1'b0}}, fin_pos_reg});
        num_b    = $signed({{(sets_pkg::DIFF_W + 2 - sets_pkg::SUM_W){1'b0}}, extra_neg});
        num_c    = {{2{best2[sets_pkg::DIFF_W-1]}}, best2};
        num_wide = num_a + num_b + num_c;

        q_job.threshold = thr2;
        q_job.numer     = num_wide[sets_pkg::DIFF_W+1] ? '0
                                                       : num_wide[sets_pkg::NUM_W-1:0];
        q_job.denom     = {2'b00, fin_pos_reg} + {2'b00, fin_neg_reg}
                        + {2'b00, extra_pos} + {2'b00, extra_neg};
        q_job.zero      = (q_job.denom == '0);
    end

endmodule

>>> rtl/sets_divider.sv
// ----------------------------------------------------------------------------
// sets_divider: error fraction unit
// Takes jobs from the queue, forms numer / denom as a Q0.32 fraction one
// quotient bit per cycle, and holds the result for the output side.
// ----------------------------------------------------------------------------
module sets_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sets_pkg::job_t        job,
    input  logic                  q_empty,
    output logic                  q_pop,
    output sets_pkg::out_item_t   result,
    output logic                  empty,
    input  logic                  pop
);

    sets_pkg::div_state_t             state_reg;
    sets_pkg::div_state_t             state_next;
    logic [sets_pkg::DEN_W-1:0]       rem_reg;
    logic [sets_pkg::DEN_W-1:0]       den_reg;
    logic [sets_pkg::ERR_W-1:0]       quo_reg;
    logic [sets_pkg::STEP_W-1:0]      step_reg;
    logic signed [sets_pkg::W_W-1:0]  thr_reg;
    logic                             zero_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    sets_pkg::out_item_t              out_reg;

    logic                             trivial;
    logic                             last_step;
    logic                             slot_free;
    logic                             load_out;
    logic [sets_pkg::DEN_W:0]         rem_shift;
    logic [sets_pkg::DEN_W:0]         rem_sub;
    logic                             q_bit;

    assign slot_free = !out_valid_reg || pop;
    assign trivial   = job.zero || ({1'b0, job.numer} >= job.denom);
    assign last_step = (step_reg == sets_pkg::STEP_W'(sets_pkg::DIV_STEPS - 1));
    assign result    = out_reg;
    assign empty     = !out_valid_reg;

    // One restoring step: shift the remainder and try the divisor.
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_sub   = rem_shift - {1'b0, den_reg};
        q_bit     = (rem_shift >= {1'b0, den_reg});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sets_pkg::DIV_IDLE:
            begin
                if (!q_empty)
                    state_next = trivial ? sets_pkg::DIV_HOLD : sets_pkg::DIV_RUN;
            end
            sets_pkg::DIV_RUN:
            begin
                if (last_step)
                    state_next = sets_pkg::DIV_HOLD;
            end
            sets_pkg::DIV_HOLD:
            begin
                if (slot_free)
                    state_next = sets_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = sets_pkg::DIV_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            sets_pkg::DIV_IDLE:
            begin
                q_pop = !q_empty;
            end
            sets_pkg::DIV_HOLD:
            begin
                load_out = slot_free;
            end
            default:
            begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    // Result slot occupancy.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b0;
        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sets_pkg::DIV_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
                step_reg <= '0;
            else if (state_reg == sets_pkg::DIV_RUN)
                step_reg <= step_reg + 1'b1;
        end
    end

    // Datapath: load a job, iterate, then move the result to the slot.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rem_reg  <= {1'b0, job.numer};
            den_reg  <= job.denom;
            thr_reg  <= job.threshold;
            zero_reg <= job.zero;
            if (job.zero)
                quo_reg <= '0;
            else if (trivial)
                quo_reg <= '1;
            else
                quo_reg <= '0;
        end
        else if (state_reg == sets_pkg::DIV_RUN)
        begin
            if (q_bit)
                rem_reg <= rem_sub[sets_pkg::DEN_W-1:0];
            else
                rem_reg <= rem_shift[sets_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[sets_pkg::ERR_W-2:0], q_bit};
        end
        if (load_out)
        begin
            out_reg.best_threshold <= thr_reg;
            out_reg.best_error     <= quo_reg;
            out_reg.zero_total     <= zero_reg;
        end
    end

endmodule

>>> rtl/sorted_edge_threshold_error_sweep.sv
// ----------------------------------------------------------------------------
// sorted_edge_threshold_error_sweep: least Rand error threshold search
// Sweeps a sorted run of edges for the merge threshold with the least error
// and reports the threshold and the error fraction at the end of each run.
//
//   channel   handshake            payload
//   -------   ------------------   -----------------------------------------
//   edges     push / full          item   (edge weight, pair counts, last)
//   results   pop / empty          result (threshold, error, zero flag)
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data (extra pair counts)
//
// The sweep takes one edge per cycle unless full; a closed run is finished in the next
// cycle and queued when the queue has room. The divider loads a job, forms 32 quotient
// bits and hands off the result, skipping the bits when the total is zero or the
// error saturates; short runs fill the two-entry queue and full rises until it drains.
// Reset clears all run state, the queue, the result slot and the extra counts. A held
// result stalls the divider, and the sweep once the queue fills.
// ----------------------------------------------------------------------------
module sorted_edge_threshold_error_sweep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  sets_pkg::in_item_t                  item,
    output logic                                empty,
    input  logic                                pop,
    output sets_pkg::out_item_t                 result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sets_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sets_pkg::SUM_W-1:0]          cfg_data
);

    logic [sets_pkg::SUM_W-1:0] extra_pos_reg;
    logic [sets_pkg::SUM_W-1:0] extra_neg_reg;
    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    sets_pkg::job_t             job_in;
    sets_pkg::job_t             job_out;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_pos_reg <= '0;
            extra_neg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sets_pkg::CFG_EXTRA_POS: extra_pos_reg <= cfg_data;
                sets_pkg::CFG_EXTRA_NEG: extra_neg_reg <= cfg_data;
                default:                 extra_pos_reg <= extra_pos_reg;
            endcase
        end
    end

    // Edge sweep.
    sets_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .extra_pos (extra_pos_reg),
        .extra_neg (extra_neg_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (job_in)
    );

    // Job queue.
    sets_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (job_in),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (job_out),
        .q_empty (q_empty)
    );

    // Error fraction unit and result slot.
    sets_divider u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .job     (job_out),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

`ifndef SYNTHESIS
    // The sweep never writes a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("job written into a full queue");

    // The divider never reads an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("job read from an empty queue");

    // A zero total always reports a zero error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.zero_total) |-> (result.best_error == '0))
        else $error("zero total with a nonzero error");
`endif

endmodule
